// ===== hdl/npcs_pkg.sv =====
// npcs_pkg: types and constants shared by the nearest palette colour search
// depends on nothing; imported by the front end, the search engine, the top level and the checker
`default_nettype none

package npcs_pkg;

  // fixed field widths
  localparam int IDX_W   = 8;
  localparam int CH_W    = 8;
  localparam int RGB_W   = 3 * CH_W;
  localparam int C15_W   = 15;
  localparam int DIST_W  = 18;
  localparam int SQ_W    = 2 * CH_W;

  // operation codes of an input transaction
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // input transaction
  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [C15_W-1:0] color15;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_distance;
  } out_item_t;

  // command handed from the front end to the search engine
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_kind_t;

  // colour holds red in bits 7:0, green in 15:8, blue in 23:16
  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [RGB_W-1:0] color;
  } cmd_t;

  // widen a 5-bit channel to c*8+4
  function automatic logic [CH_W-1:0] widen5(input logic [4:0] c);
    widen5 = {c, 3'b100};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/npcs_ram.sv =====
// npcs_ram: generic single write port ram with registered read
// depends on nothing
`default_nettype none

module npcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/npcs_front.sv =====
// npcs_front: accepts input transactions, classifies them and queues commands
// depends on npcs_pkg
`default_nettype none

module npcs_front #(
  parameter int PALETTE_SIZE = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output      logic              full,
  input  wire npcs_pkg::in_item_t request,
  output      logic              cmd_valid,
  input  wire logic              cmd_take,
  output      npcs_pkg::cmd_t    cmd
);
  import npcs_pkg::*;

  localparam int QDEPTH = 2;

  cmd_t       q_mem [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       in_range;
  logic       enq;
  logic       deq;
  cmd_t       cmd_in;

  // classify: writes beyond the palette are dropped here
  assign in_range = {1'b0, request.entry_index} < (IDX_W + 1)'(PALETTE_SIZE);

  always_comb begin
    cmd_in.idx = request.entry_index;
    if (request.op == OP_QUERY) begin
      cmd_in.kind  = CMD_QUERY;
      cmd_in.color = {widen5(request.color15[14:10]),
                      widen5(request.color15[9:5]),
                      widen5(request.color15[4:0])};
    end else begin
      cmd_in.kind  = CMD_WRITE;
      cmd_in.color = {request.blue, request.green, request.red};
    end
  end

  assign full      = (count == 2'(QDEPTH));
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q_mem[rd_ptr];
  assign enq       = push && !full && ((request.op == OP_QUERY) || in_range);
  assign deq       = cmd_take && cmd_valid;

  // queue occupancy
  always_comb begin
    count_next = count;
    if (enq && !deq) begin
      count_next = count + 2'd1;
    end else if (deq && !enq) begin
      count_next = count - 2'd1;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/npcs_back.sv =====
// npcs_back: palette store and nearest colour search engine with result register
// depends on npcs_pkg and npcs_ram
`default_nettype none

module npcs_back #(
  parameter int PALETTE_SIZE = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output      logic               cmd_take,
  input  wire npcs_pkg::cmd_t     cmd,
  output      logic               empty,
  input  wire logic               pop,
  output      npcs_pkg::out_item_t result
);
  import npcs_pkg::*;

  localparam int AW = $clog2(PALETTE_SIZE);
  localparam logic [AW-1:0] LAST = AW'(PALETTE_SIZE - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  state_t                  state;
  logic [PALETTE_SIZE-1:0] valid_bits;
  logic [RGB_W-1:0]        qcol;
  logic [AW-1:0]           cnt;
  logic                    ram_we;
  logic                    ram_re;
  logic [RGB_W-1:0]        ram_rdata;
  // stage one: ram data in flight
  logic                    s1_v;
  logic                    s1_ok;
  logic                    s1_last;
  logic [AW-1:0]           s1_idx;
  logic [RGB_W-1:0]        entry;
  logic [CH_W-1:0]         diff_r;
  logic [CH_W-1:0]         diff_g;
  logic [CH_W-1:0]         diff_b;
  // stage two: squared channel distances
  logic                    s2_v;
  logic                    s2_first;
  logic                    s2_last;
  logic [AW-1:0]           s2_idx;
  logic [SQ_W-1:0]         sq_r;
  logic [SQ_W-1:0]         sq_g;
  logic [SQ_W-1:0]         sq_b;
  logic [DIST_W-1:0]       cand_d;
  // running best
  logic [AW-1:0]           best_idx;
  logic [DIST_W-1:0]       best_d;
  logic                    fin;
  logic                    res_valid;
  logic                    res_free;

  assign cmd_take = cmd_valid && (state == ST_IDLE);
  assign ram_we   = cmd_take && (cmd.kind == CMD_WRITE);
  assign ram_re   = (state == ST_SCAN);
  assign res_free = !res_valid || pop;
  assign empty    = !res_valid;

  npcs_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_SIZE)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.idx[AW-1:0]),
    .wdata (cmd.color),
    .re    (ram_re),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  // sequencer and entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid_bits <= '0;
      cnt        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ram_we) begin
            valid_bits[cmd.idx[AW-1:0]] <= 1'b1;
          end
          if (cmd_take && (cmd.kind == CMD_QUERY)) begin
            cnt   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + AW'(1);
          if (cnt == LAST) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (fin) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // latch the widened query colour
  always_ff @(posedge clk) begin
    if (cmd_take && (cmd.kind == CMD_QUERY)) begin
      qcol <= cmd.color;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      fin  <= 1'b0;
    end else begin
      s1_v <= ram_re;
      s2_v <= s1_v;
      fin  <= s2_v && s2_last;
    end
  end

  // stage one side info, aligned with the ram read data
  always_ff @(posedge clk) begin
    s1_ok   <= valid_bits[cnt];
    s1_idx  <= cnt;
    s1_last <= (cnt == LAST);
  end

  // never written entries read as black
  assign entry  = s1_ok ? ram_rdata : '0;
  assign diff_r = (qcol[7:0] >= entry[7:0]) ? qcol[7:0] - entry[7:0]
                                            : entry[7:0] - qcol[7:0];
  assign diff_g = (qcol[15:8] >= entry[15:8]) ? qcol[15:8] - entry[15:8]
                                              : entry[15:8] - qcol[15:8];
  assign diff_b = (qcol[23:16] >= entry[23:16]) ? qcol[23:16] - entry[23:16]
                                                : entry[23:16] - qcol[23:16];

  // squared channel differences
  always_ff @(posedge clk) begin
    sq_r     <= diff_r * diff_r;
    sq_g     <= diff_g * diff_g;
    sq_b     <= diff_b * diff_b;
    s2_idx   <= s1_idx;
    s2_last  <= s1_last;
    s2_first <= (s1_idx == '0);
  end

  assign cand_d = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  // keep the first strictly smaller distance, so ties stay at the lowest index
  always_ff @(posedge clk) begin
    if (s2_v && (s2_first || (cand_d < best_d))) begin
      best_d   <= cand_d;
      best_idx <= s2_idx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == ST_HOLD) && res_free) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_HOLD) && res_free) begin
      result.best_index    <= IDX_W'(best_idx);
      result.best_distance <= best_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nearest_palette_color_search.sv =====
// nearest_palette_color_search: top level, front end queue plus search engine
// depends on npcs_pkg, npcs_front, npcs_back
//
//   channel   handshake          payload               transactions
//   input     push / full        request (in_item_t)   palette write or colour query
//   result    pop / empty        result (out_item_t)   one per query, none per write
//
// a palette write reaches the store at the edge after its acceptance when the engine is idle
// and no command waits ahead; a query reads one palette entry per cycle over the palette
// ram's single read port, then drains a short pipeline on its way to the result ports
// rst is synchronous; the palette reads as black until each entry is written
// a waiting result holds the engine once the next query has finished; transactions then
// back up in the two-entry queue, which raises full
`default_nettype none

module nearest_palette_color_search #(
  parameter int PALETTE_SIZE = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output      logic                full,
  input  wire npcs_pkg::in_item_t  request,
  output      logic                empty,
  input  wire logic                pop,
  output      npcs_pkg::out_item_t result
);
  import npcs_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // front end: classification and command queue
  npcs_front #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  // back end: palette store and search
  npcs_back #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== hdl/npcs_checker.sv =====
// npcs_checker: port level assertions for the nearest palette colour search
// depends on npcs_pkg; bound to nearest_palette_color_search below
`default_nettype none

module npcs_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                push,
  input wire logic                full,
  input wire npcs_pkg::in_item_t  request,
  input wire logic                empty,
  input wire logic                pop,
  input wire npcs_pkg::out_item_t result
);
  import npcs_pkg::*;

  localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(190512);

  // reset leaves no result transaction waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending right after reset");

  // reset leaves the input queue with room
  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("input queue full right after reset");

  // a waiting result holds until it is popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // a widened query colour is never further than three times 252 squared
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.best_distance <= MAX_DIST))
    else $error("distance out of range");

  // an offered input transaction carries defined fields
  a_push_known: assert property (@(posedge clk) disable iff (rst)
    push |-> !$isunknown(request))
    else $error("input transaction with unknown fields");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
  .clk     (clk),
  .rst     (rst),
  .push    (push),
  .full    (full),
  .request (request),
  .empty   (empty),
  .pop     (pop),
  .result  (result)
);

`default_nettype wire
